[hw/rtl/lrl_pkg.sv]
package lrl_pkg;

  localparam int unsigned COORD_W = 4;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned ROT_W   = 2;
  localparam int unsigned ERR_W   = 7;

  typedef enum logic [ROT_W-1:0] {
    ROT_NONE    = 2'd0,
    ROT_MINUS90 = 2'd1,
    ROT_PLUS90  = 2'd2,
    ROT_FLIPPED = 2'd3
  } lrl_rot_e;

  typedef struct packed {
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] final_x;
    logic [COORD_W-1:0] final_y;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
  } lrl_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] led_index;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;
    logic               last_pixel;
  } lrl_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } lrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } lrl_sts_t;

endpackage

[hw/rtl/lrl_ctrl.sv]
module lrl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lrl_pkg::lrl_cmd_t cmd_o,
  input  lrl_pkg::lrl_sts_t sts_i
);
  import lrl_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.emit = (state_q == ST_WALK) && out_free;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cmd_o.emit && sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/lrl_datapath.sv]
module lrl_datapath #(
  parameter int unsigned GRID_COLS = 16,
  parameter int unsigned GRID_ROWS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lrl_pkg::lrl_cmd_t           cmd_i,
  output lrl_pkg::lrl_sts_t           sts_o,
  input  lrl_pkg::lrl_in_t            in_data_i,
  input  logic                        cfg_we_i,
  input  logic [lrl_pkg::ROT_W-1:0]   cfg_data_i,
  output lrl_pkg::lrl_out_t           out_data_o
);
  import lrl_pkg::*;

  // coordinates above the grid saturate; a 4-bit field never exceeds a wide grid
  localparam int unsigned COORD_SPAN = 2 ** COORD_W;
  localparam int unsigned COL_LIM = (GRID_COLS > COORD_SPAN) ? COORD_SPAN : GRID_COLS;
  localparam int unsigned ROW_LIM = (GRID_ROWS > COORD_SPAN) ? COORD_SPAN : GRID_ROWS;
  localparam logic [COORD_W:0]   COL_LIM_V = (COORD_W+1)'(COL_LIM);
  localparam logic [COORD_W:0]   ROW_LIM_V = (COORD_W+1)'(ROW_LIM);
  localparam logic [COORD_W-1:0] COL_TOP   = COORD_W'(COL_LIM - 1);
  localparam logic [COORD_W-1:0] ROW_TOP   = COORD_W'(ROW_LIM - 1);
  localparam logic [INDEX_W-1:0] COLS_V    = INDEX_W'(GRID_COLS);
  localparam logic [INDEX_W-1:0] ROWS_V    = INDEX_W'(GRID_ROWS);

  logic [ROT_W-1:0]   rot_q;
  logic [COORD_W-1:0] walk_x_q, walk_x_d, walk_y_q, walk_y_d;
  logic [COORD_W-1:0] tgt_x_q, tgt_y_q;
  logic [COORD_W-1:0] dx_q, dy_q;
  logic [1:0]         signs_q;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic [3*COLOR_W-1:0]    color_q;
  lrl_out_t           out_q, out_d;

  logic [COORD_W-1:0] x0, y0, x1, y1;
  logic signed [ERR_W:0] e2;
  logic step_x, step_y;
  logic [INDEX_W-1:0] wx, wy, idx;

  // endpoint saturation
  always_comb begin
    x0 = ({1'b0, in_data_i.first_x} >= COL_LIM_V) ? COL_TOP : in_data_i.first_x;
    y0 = ({1'b0, in_data_i.first_y} >= ROW_LIM_V) ? ROW_TOP : in_data_i.first_y;
    x1 = ({1'b0, in_data_i.final_x} >= COL_LIM_V) ? COL_TOP : in_data_i.final_x;
    y1 = ({1'b0, in_data_i.final_y} >= ROW_LIM_V) ? ROW_TOP : in_data_i.final_y;
  end

  // bresenham step
  always_comb begin
    e2       = {err_q, 1'b0};
    step_x   = (e2 >= -$signed({{(ERR_W-COORD_W+1){1'b0}}, dy_q}));
    step_y   = (e2 <= $signed({{(ERR_W-COORD_W+1){1'b0}}, dx_q}));
    err_d    = err_q;
    walk_x_d = walk_x_q;
    walk_y_d = walk_y_q;
    if (step_x) begin
      err_d    = err_d - $signed({{(ERR_W-COORD_W){1'b0}}, dy_q});
      walk_x_d = signs_q[0] ? walk_x_q - 1'b1 : walk_x_q + 1'b1;
    end
    if (step_y) begin
      err_d    = err_d + $signed({{(ERR_W-COORD_W){1'b0}}, dx_q});
      walk_y_d = signs_q[1] ? walk_y_q - 1'b1 : walk_y_q + 1'b1;
    end
  end

  assign sts_o.last = (walk_x_q == tgt_x_q) && (walk_y_q == tgt_y_q);

  // serpentine index, kept modulo 256
  always_comb begin
    wx = INDEX_W'(walk_x_q);
    wy = INDEX_W'(walk_y_q);
    case (lrl_rot_e'(rot_q))
      ROT_NONE:    idx = INDEX_W'(wy * COLS_V) + (wy[0] ? wx : COLS_V - 1'b1 - wx);
      ROT_MINUS90: idx = INDEX_W'(wx * ROWS_V) + (wx[0] ? wy : ROWS_V - 1'b1 - wy);
      ROT_PLUS90:  idx = INDEX_W'(wx * ROWS_V) + (wx[0] ? ROWS_V - 1'b1 - wy : wy);
      ROT_FLIPPED: idx = INDEX_W'(wy * COLS_V) + (wy[0] ? COLS_V - 1'b1 - wx : wx);
      default:     idx = '0;
    endcase
  end

  always_comb begin
    out_d.led_index  = idx;
    out_d.red_out    = color_q[3*COLOR_W-1:2*COLOR_W];
    out_d.green_out  = color_q[2*COLOR_W-1:COLOR_W];
    out_d.blue_out   = color_q[COLOR_W-1:0];
    out_d.last_pixel = sts_o.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q    <= ROT_NONE;
      walk_x_q <= '0;
      walk_y_q <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      signs_q  <= '0;
      err_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        rot_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        walk_x_q <= x0;
        walk_y_q <= y0;
        tgt_x_q  <= x1;
        tgt_y_q  <= y1;
        dx_q     <= (x1 >= x0) ? x1 - x0 : x0 - x1;
        dy_q     <= (y1 >= y0) ? y1 - y0 : y0 - y1;
        signs_q  <= {!(y0 < y1), !(x0 < x1)};
        err_q    <= $signed({{(ERR_W-COORD_W){1'b0}}, ((x1 >= x0) ? x1 - x0 : x0 - x1)})
                  - $signed({{(ERR_W-COORD_W){1'b0}}, ((y1 >= y0) ? y1 - y0 : y0 - y1)});
      end else if (cmd_i.emit) begin
        walk_x_q <= walk_x_d;
        walk_y_q <= walk_y_d;
        err_q    <= err_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      color_q <= {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

[hw/rtl/line_rasterizer_to_led_strip.sv]
// Line rasterizer for a serpentine LED strip. Each input item carries two grid
// endpoints and a 24-bit colour; the block walks the integer Bresenham line
// from the first endpoint to the final one, both included, and sends one
// output item per pixel with its strip position, the colour and a flag on the
// last pixel. Endpoint coordinates beyond the grid saturate to its edge. The
// strip position follows rotation_mode, to be written through the cfg channel
// only while the block is idle, which the block itself does not enforce (0 none,
// 1 minus ninety, 2 plus ninety, 3 flipped); the index wraps to 8 bits on
// grids larger than 256 pixels. A line has N = max(|dx|,|dy|)+1 pixels, at
// most 16: the endpoints load at the accepting edge, then the single step
// unit walks one pixel per cycle while the output side does not stall, and
// the block goes back to idle, where the next item can be accepted. The last
// pixel may still wait in the output register while the next line is being
// accepted.
module line_rasterizer_to_led_strip #(
  parameter int unsigned GRID_COLS = 16,
  parameter int unsigned GRID_ROWS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // line requests
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lrl_pkg::lrl_in_t          in_data_i,
  // pixels
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lrl_pkg::lrl_out_t         out_data_o,
  // rotation register
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lrl_pkg::ROT_W-1:0] cfg_data_i
);
  import lrl_pkg::*;

  lrl_cmd_t cmd;
  lrl_sts_t sts;

  // the register can always be written
  assign cfg_ready_o = 1'b1;

  // sequencer: idle / walking, plus output valid
  lrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // walk state, error term, index mapping and output register
  lrl_datapath #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

  // an accepted line always leaves at least one pixel to walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after accepting a line");

  // emitting the final pixel frees the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && sts.last) |=> !in_stall_o)
    else $error("block still busy after the last pixel");

  // a waiting pixel is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd.emit)
    else $error("output register overwritten while stalled");

  // no load while a line is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && cmd.emit))
    else $error("load and emit in the same cycle");

endmodule

[sim/tb_top.sv]
module tb_top;
  import lrl_pkg::*;

  localparam int unsigned GRID_COLS  = 16;
  localparam int unsigned GRID_ROWS  = 16;
  localparam int unsigned ODD_MASK   = 'h01;
  localparam int unsigned CALM_TAIL  = 20;      // last items run with no idling
  localparam int unsigned SETTLE     = 4;       // quiet cycles before a register write
  localparam int unsigned TAIL_WAIT  = 40;
  localparam int unsigned CYCLE_CAP  = 300000;
  localparam int unsigned PHASE_LEN  = 23;

  typedef enum logic [1:0] {
    OP_LINE,
    OP_ROTATE,
    OP_DRAIN
  } op_kind_e;

  typedef struct {
    op_kind_e kind;
    lrl_in_t  line;
    lrl_rot_e rot;
  } op_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  lrl_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  lrl_out_t            out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [ROT_W-1:0]    cfg_data_i  = ROT_NONE;

  op_t      pending_ops[$];
  lrl_out_t pixel_q[$];       // pixels still owed by the block, oldest first
  lrl_rot_e rotation = ROT_NONE;
  int       errors = 0;
  int       cycles = 0;

  line_rasterizer_to_led_strip #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // serpentine strip position of one grid pixel under a given rotation
  function automatic logic [INDEX_W-1:0] strip_index(int x, int y, lrl_rot_e rot);
    int pos;
    case (rot)
      ROT_NONE: begin
        pos = (y & ODD_MASK) ? y * GRID_COLS + x : y * GRID_COLS + GRID_COLS - 1 - x;
      end
      ROT_MINUS90: begin
        pos = (x & ODD_MASK) ? x * GRID_ROWS + y : x * GRID_ROWS + GRID_ROWS - 1 - y;
      end
      ROT_PLUS90: begin
        pos = (x & ODD_MASK) ? x * GRID_ROWS + GRID_ROWS - 1 - y : x * GRID_ROWS + y;
      end
      default: begin
        pos = (y & ODD_MASK) ? y * GRID_COLS + GRID_COLS - 1 - x : y * GRID_COLS + x;
      end
    endcase
    return pos[INDEX_W-1:0];
  endfunction

  // walk the integer line and queue every pixel it should produce
  task automatic plot_line(input lrl_in_t req, input lrl_rot_e rot);
    int x0, y0, x1, y1;
    int dx, dy, sx, sy, err, e2, x, y;
    bit done;
    lrl_out_t pix;
    // endpoints saturate at the grid edge
    x0 = (req.first_x >= GRID_COLS) ? GRID_COLS - 1 : req.first_x;
    y0 = (req.first_y >= GRID_ROWS) ? GRID_ROWS - 1 : req.first_y;
    x1 = (req.final_x >= GRID_COLS) ? GRID_COLS - 1 : req.final_x;
    y1 = (req.final_y >= GRID_ROWS) ? GRID_ROWS - 1 : req.final_y;
    dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
    dy = (y1 >= y0) ? y0 - y1 : y1 - y0;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    x = x0;
    y = y0;
    done = 1'b0;
    while (!done) begin
      done = (x == x1) && (y == y1);
      pix.led_index  = strip_index(x, y, rot);
      pix.red_out    = req.red_in;
      pix.green_out  = req.green_in;
      pix.blue_out   = req.blue_in;
      pix.last_pixel = done;
      pixel_q.push_back(pix);
      if (!done) begin
        e2 = 2 * err;
        if (e2 >= dy) begin
          err += dy;
          x += sx;
        end
        if (e2 <= dx) begin
          err += dx;
          y += sy;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  function automatic lrl_in_t make_line(int fx, int fy, int tx, int ty,
                                        int r, int g, int b);
    lrl_in_t req;
    req.first_x  = COORD_W'(fx);
    req.first_y  = COORD_W'(fy);
    req.final_x  = COORD_W'(tx);
    req.final_y  = COORD_W'(ty);
    req.red_in   = COLOR_W'(r);
    req.green_in = COLOR_W'(g);
    req.blue_in  = COLOR_W'(b);
    return req;
  endfunction

  task automatic queue_line(input lrl_in_t req);
    op_t op;
    op.kind = OP_LINE;
    op.line = req;
    op.rot  = ROT_NONE;
    pending_ops.push_back(op);
  endtask

  function automatic lrl_in_t random_line();
    lrl_in_t req;
    int pick;
    req.first_x  = COORD_W'($urandom_range(0, 15));
    req.first_y  = COORD_W'($urandom_range(0, 15));
    req.final_x  = COORD_W'($urandom_range(0, 15));
    req.final_y  = COORD_W'($urandom_range(0, 15));
    req.red_in   = COLOR_W'($urandom_range(0, 255));
    req.green_in = COLOR_W'($urandom_range(0, 255));
    req.blue_in  = COLOR_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      // single point
      req.final_x = req.first_x;
      req.final_y = req.first_y;
    end else if (pick == 1) begin
      // edge to edge, horizontal or vertical
      if ($urandom_range(0, 1)) begin
        req.first_x = COORD_W'(0);
        req.final_x = COORD_W'(15);
        req.final_y = req.first_y;
      end else begin
        req.first_y = COORD_W'(15);
        req.final_y = COORD_W'(0);
        req.final_x = req.first_x;
      end
    end
    return req;
  endfunction

  // driver: feeds line items and register writes from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic     line_done, cfg_done, nxt_in_valid, nxt_cfg_valid;
    int       gap;
    int       settle;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
      in_data_i   <= '0;
      cfg_data_i  <= ROT_NONE;
      gap = 0;
      settle = 0;
    end else begin
      line_done = in_valid_i && !in_stall_o;
      cfg_done  = cfg_valid_i && cfg_ready_o;
      // an accepted line is predicted with the rotation in force now
      if (line_done) begin
        plot_line(in_data_i, rotation);
        void'(pending_ops.pop_front());
      end
      if (cfg_done) begin
        rotation = lrl_rot_e'(cfg_data_i);
        void'(pending_ops.pop_front());
      end
      nxt_in_valid  = in_valid_i && !line_done;
      nxt_cfg_valid = cfg_valid_i && !cfg_done;
      if (!nxt_in_valid && !nxt_cfg_valid) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
          gap = $urandom_range(0, 11);
        end else if (pending_ops.size() > 0) begin
          case (pending_ops[0].kind)
            OP_LINE: begin
              nxt_in_valid = 1'b1;
              in_data_i <= pending_ops[0].line;
            end
            default: begin
              // register writes and drain points wait for the block to go quiet
              if (pixel_q.size() != 0) begin
                settle = 0;
              end else if (settle < SETTLE) begin
                settle++;
              end else begin
                settle = 0;
                if (pending_ops[0].kind == OP_ROTATE) begin
                  nxt_cfg_valid = 1'b1;
                  cfg_data_i <= pending_ops[0].rot;
                end else begin
                  void'(pending_ops.pop_front());
                end
              end
            end
          endcase
        end
      end
      in_valid_i  <= nxt_in_valid;
      cfg_valid_i <= nxt_cfg_valid;
    end
  end

  // monitor: checks each accepted pixel against the oldest one owed, and
  // stalls the output in random bursts
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    lrl_out_t want;
    int       hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          $error("pixel with no line pending: led_index %0d", out_data_o.led_index);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          check_field("led_index", want.led_index, out_data_o.led_index);
          check_field("red_out", want.red_out, out_data_o.red_out);
          check_field("green_out", want.green_out, out_data_o.green_out);
          check_field("blue_out", want.blue_out, out_data_o.blue_out);
          check_field("last_pixel", want.last_pixel, out_data_o.last_pixel);
        end
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 11);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("line_rasterizer_to_led_strip: mismatch");
      $finish;
    end
  end

  initial begin : stim_proc
    lrl_rot_e phases[5];
    op_t      op;
    phases = '{ROT_FLIPPED, ROT_MINUS90, ROT_PLUS90, ROT_NONE, ROT_FLIPPED};

    // directed lines under the reset rotation
    queue_line(make_line(0, 0, 0, 0, 'h00, 'h00, 'h00));      // single point, black
    queue_line(make_line(15, 15, 15, 15, 'hff, 'hff, 'hff));  // single point, far corner
    queue_line(make_line(0, 0, 15, 0, 'hff, 'h00, 'h00));
    queue_line(make_line(15, 0, 0, 0, 'h00, 'hff, 'h00));
    queue_line(make_line(0, 0, 0, 15, 'h00, 'h00, 'hff));
    queue_line(make_line(0, 15, 0, 0, 'haa, 'h55, 'haa));
    queue_line(make_line(0, 0, 15, 15, 'h55, 'haa, 'h55));
    queue_line(make_line(15, 15, 0, 0, 'h01, 'h80, 'h7f));
    queue_line(make_line(15, 0, 0, 15, 'h80, 'h7f, 'h01));
    queue_line(make_line(0, 15, 15, 0, 'h7f, 'h01, 'h80));
    queue_line(make_line(0, 0, 15, 7, 'h12, 'h34, 'h56));     // shallow
    queue_line(make_line(3, 1, 9, 14, 'h9a, 'hbc, 'hde));     // steep
    queue_line(make_line(14, 2, 1, 5, 'hfe, 'hdc, 'hba));
    queue_line(make_line(5, 12, 7, 1, 'h0f, 'hf0, 'h3c));
    queue_line(make_line(15, 8, 15, 9, 'hc3, 'h69, 'h96));

    // hold off until every pixel of the directed lines is back
    op.kind = OP_DRAIN;
    op.line = '0;
    op.rot  = ROT_NONE;
    pending_ops.push_back(op);

    // random lines under each rotation in turn
    foreach (phases[p]) begin
      op.kind = OP_ROTATE;
      op.rot  = phases[p];
      pending_ops.push_back(op);
      repeat (PHASE_LEN) queue_line(random_line());
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_ops.size() != 0 || in_valid_i || cfg_valid_i || pixel_q.size() != 0);
    repeat (TAIL_WAIT) @(negedge clk_i);

    if (errors == 0) begin
      $display("line_rasterizer_to_led_strip: match");
    end else begin
      $display("line_rasterizer_to_led_strip: mismatch");
    end
    $finish;
  end

endmodule
